// ----- design/lict_pkg.sv -----
package lict_pkg;

    localparam int DEF_COUNT_BITS = 32;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [9:0] OFS_ID  = 10'h020;
    localparam logic [9:0] OFS_TPR = 10'h080;
    localparam logic [9:0] OFS_EOI = 10'h0B0;
    localparam logic [9:0] OFS_SVR = 10'h0F0;
    localparam logic [9:0] OFS_LVT = 10'h320;
    localparam logic [9:0] OFS_ICR = 10'h380;
    localparam logic [9:0] OFS_CCR = 10'h390;
    localparam logic [9:0] OFS_DIV = 10'h3E0;

    localparam logic [8:0] SVR_RESET = 9'h0FF;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_fire;
        logic [7:0]  irq_vector;
        logic        eoi_pulse;
    } t_result;

endpackage

// ----- design/local_interrupt_controller_timer.sv -----
// Timer register block of a local interrupt controller. Each request on the
// slave stream is a bus-clock tick, a register read or a register write, and
// gives exactly one result on the master stream in the cycle after it is taken.
// One request is taken every cycle; the only stall comes from the master
// side holding a result, since the single output register must drain before
// the next request can be taken. Registers: ID 0x020, TPR 0x080, EOI 0x0B0,
// SVR 0x0F0, timer LVT 0x320, initial count 0x380, current count 0x390 and
// divide 0x3E0; offset bits 3:0 are ignored and unknown offsets read zero.
module local_interrupt_controller_timer #(
    parameter int COUNT_BITS = lict_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // controller_id
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // register_offset[9:0], write_data[41:10], zero
    input  logic [1:0]  s_axis_tuser,    // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata     // read_data[31:0], irq_fire[32],
                                         // irq_vector[40:33], eoi_pulse[41], zero
);

    logic              r_out_valid;
    lict_pkg::t_result r_out;
    lict_pkg::t_result core_result;
    logic              take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    lict_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (take),
        .i_mode        (s_axis_tuser),
        .i_offset      (s_axis_tdata[9:0]),
        .i_data        (s_axis_tdata[41:10]),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out.eoi_pulse, r_out.irq_vector,
                            r_out.irq_fire, r_out.read_data};

endmodule

// ----- design/lict_core.sv -----
module lict_core #(
    parameter int COUNT_BITS = lict_pkg::DEF_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_req,
    input  logic [1:0]         i_mode,
    input  logic [9:0]         i_offset,
    input  logic [31:0]        i_data,
    output lict_pkg::t_result  o_result
);

    logic [7:0]            r_id;
    logic [8:0]            r_svr;
    logic [7:0]            r_tpr;
    logic [7:0]            r_lvt_vec;
    logic                  r_lvt_mask;
    logic                  r_lvt_per;
    logic [3:0]            r_div;
    logic [COUNT_BITS-1:0] r_init;
    logic [COUNT_BITS-1:0] r_cur;
    logic [6:0]            r_pre;

    logic [COUNT_BITS-1:0] n_cur;
    logic [6:0]            n_pre;
    logic [COUNT_BITS-1:0] cur_dec;
    logic [2:0]            div_code;
    logic [7:0]            divisor;
    logic                  pre_wrap;
    logic [9:0]            ofs;
    logic                  is_tick;
    logic                  is_read;
    logic                  is_write;

    assign ofs      = {i_offset[9:4], 4'b0000};
    assign is_tick  = i_req && (i_mode == lict_pkg::MODE_TICK);
    assign is_read  = i_req && (i_mode == lict_pkg::MODE_READ);
    assign is_write = i_req && (i_mode == lict_pkg::MODE_WRITE);

    // Divide code bits 3,1,0 form the prescale code; all ones means divide by one.
    assign div_code = {r_div[3], r_div[1:0]};
    assign divisor  = (div_code == 3'd7) ? 8'd1 : (8'd2 << div_code);
    assign pre_wrap = !(({1'b0, r_pre} + 8'd1) < divisor);
    assign cur_dec  = r_cur - {{(COUNT_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        n_cur             = r_cur;
        n_pre             = r_pre;
        o_result          = '0;
        if (is_tick && (r_cur != '0)) begin
            if (!pre_wrap) begin
                n_pre = r_pre + 7'd1;
            end else begin
                n_pre = '0;
                n_cur = cur_dec;
                if (cur_dec == '0) begin
                    if (r_lvt_per) begin
                        n_cur = r_init;
                    end
                    if (!r_lvt_mask && r_svr[8]) begin
                        o_result.irq_fire   = 1'b1;
                        o_result.irq_vector = r_lvt_vec;
                    end
                end
            end
        end
        if (is_write && (ofs == lict_pkg::OFS_ICR)) begin
            n_cur = i_data[COUNT_BITS-1:0];
            n_pre = '0;
        end
        if (is_write && (ofs == lict_pkg::OFS_EOI)) begin
            o_result.eoi_pulse = 1'b1;
        end
        if (is_read) begin
            unique case (ofs)
                lict_pkg::OFS_ID:  o_result.read_data = {r_id, 24'h000000};
                lict_pkg::OFS_TPR: o_result.read_data = {24'h000000, r_tpr};
                lict_pkg::OFS_SVR: o_result.read_data = {23'h000000, r_svr};
                lict_pkg::OFS_LVT: o_result.read_data =
                    {14'h0000, r_lvt_per, r_lvt_mask, 8'h00, r_lvt_vec};
                lict_pkg::OFS_ICR: o_result.read_data = 32'(r_init);
                lict_pkg::OFS_CCR: o_result.read_data = 32'(r_cur);
                lict_pkg::OFS_DIV: o_result.read_data = {28'h0000000, r_div};
                default:           o_result.read_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id       <= '0;
            r_svr      <= lict_pkg::SVR_RESET;
            r_tpr      <= '0;
            r_lvt_vec  <= '0;
            r_lvt_mask <= 1'b1;
            r_lvt_per  <= 1'b0;
            r_div      <= '0;
            r_init     <= '0;
            r_cur      <= '0;
            r_pre      <= '0;
        end else begin
            r_cur <= n_cur;
            r_pre <= n_pre;
            if (i_cfg_wr_en) begin
                r_id <= i_cfg_wr_data;
            end
            if (is_write) begin
                unique case (ofs)
                    lict_pkg::OFS_TPR: r_tpr <= i_data[7:0];
                    lict_pkg::OFS_SVR: r_svr <= i_data[8:0];
                    lict_pkg::OFS_LVT: begin
                        r_lvt_vec  <= i_data[7:0];
                        r_lvt_mask <= i_data[16];
                        r_lvt_per  <= i_data[17];
                    end
                    lict_pkg::OFS_ICR: r_init <= i_data[COUNT_BITS-1:0];
                    lict_pkg::OFS_DIV: r_div <= {i_data[3], 1'b0, i_data[1:0]};
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- design/lict_checker.sv -----
module lict_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // Every accepted request leaves a result behind in the next cycle.
    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    // A held result blocks new requests.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while result stalled");

    // No result appears without a request behind it.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) && !(s_axis_tvalid && s_axis_tready)
        |=> !m_axis_tvalid)
        else $error("result appeared without a request");

    // A vector is only shown with an interrupt.
    a_vec_with_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[40:33] == 8'h00))
        else $error("vector without interrupt");

    // An end-of-interrupt write neither reads data nor fires the timer.
    a_eoi_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[41])
        |-> (!m_axis_tdata[32] && (m_axis_tdata[31:0] == 32'h00000000)))
        else $error("end of interrupt mixed with other results");

endmodule

bind local_interrupt_controller_timer lict_checker u_lict_checker (.*);
